### rtl/dtwr_pkg.sv
// Shared types and constants for the two-way-ranging time-of-flight block.
// No dependencies; every other file imports this package.
package dtwr_pkg;

  localparam int unsigned IN_W  = 32;  // width of each timestamp field
  localparam int unsigned OUT_W = 34;  // width of the signed flight result

  // Side information that travels with an item through the divider
  typedef struct packed {
    logic neg;      // numerator was negative
    logic invalid;  // interval sum was zero
  } dtwr_tag_t;

endpackage

### rtl/dtwr_in_if.sv
// Input channel: six timestamps of one ranging exchange per beat.
// Depends on dtwr_pkg for the field width.
interface dtwr_in_if import dtwr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IN_W-1:0]   poll_rx_time;
  logic [IN_W-1:0]   resp_tx_stamp;
  logic [IN_W-1:0]   final_rx_time;
  logic [IN_W-1:0]   remote_poll_tx_time;
  logic [IN_W-1:0]   remote_resp_rx_time;
  logic [IN_W-1:0]   remote_final_tx_time;

  modport source  (output valid, poll_rx_time, resp_tx_stamp, final_rx_time,
                   remote_poll_tx_time, remote_resp_rx_time, remote_final_tx_time,
                   input ready);
  modport sink    (input valid, poll_rx_time, resp_tx_stamp, final_rx_time,
                   remote_poll_tx_time, remote_resp_rx_time, remote_final_tx_time,
                   output ready);
  modport monitor (input valid, ready, poll_rx_time, resp_tx_stamp, final_rx_time,
                   remote_poll_tx_time, remote_resp_rx_time, remote_final_tx_time);
endinterface

### rtl/dtwr_out_if.sv
// Result channel: signed time of flight and invalid flag per beat.
// Depends on dtwr_pkg for the field width.
interface dtwr_out_if import dtwr_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] flight_ticks;
  logic                    invalid;

  modport source  (output valid, flight_ticks, invalid, input ready);
  modport sink    (input valid, flight_ticks, invalid, output ready);
  modport monitor (input valid, ready, flight_ticks, invalid);
endinterface

### rtl/dtwr_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, STAMP_BITS stages.
// Depends on dtwr_pkg for the tag type.
module dtwr_div_pipe import dtwr_pkg::*; #(
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [2*STAMP_BITS-1:0]   in_num,
  input  logic [STAMP_BITS+1:0]     in_den,
  input  dtwr_tag_t                 in_tag,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STAMP_BITS-1:0]     out_quo,
  output dtwr_tag_t                 out_tag
);

  localparam int unsigned S  = STAMP_BITS;
  localparam int unsigned RW = S + 2;  // remainder stays below the divisor

  logic            v_r   [S];
  logic            rdy   [S];
  logic [RW-1:0]   rem_r [S];
  logic [S-1:0]    lo_r  [S];
  logic [S-1:0]    quo_r [S];
  logic [RW-1:0]   den_r [S];
  dtwr_tag_t       tag_r [S];

  for (genvar k = 0; k < S; k++) begin : g_stage
    logic            p_v;
    logic [RW-1:0]   p_rem;
    logic [S-1:0]    p_lo;
    logic [S-1:0]    p_quo;
    logic [RW-1:0]   p_den;
    dtwr_tag_t       p_tag;
    logic [RW:0]     trial;
    logic [RW:0]     diff;
    logic            ge;

    if (k == 0) begin : g_first
      // top half of the numerator is already below the divisor
      assign p_v   = in_valid;
      assign p_rem = RW'(in_num[2*S-1:S]);
      assign p_lo  = in_num[S-1:0];
      assign p_quo = '0;
      assign p_den = in_den;
      assign p_tag = in_tag;
    end else begin : g_next
      assign p_v   = v_r[k-1];
      assign p_rem = rem_r[k-1];
      assign p_lo  = lo_r[k-1];
      assign p_quo = quo_r[k-1];
      assign p_den = den_r[k-1];
      assign p_tag = tag_r[k-1];
    end

    if (k == S - 1) begin : g_rdy_last
      assign rdy[k] = !v_r[k] || out_ready;
    end else begin : g_rdy_mid
      assign rdy[k] = !v_r[k] || rdy[k+1];
    end

    assign trial = {p_rem, p_lo[S-1]};
    assign ge    = trial >= {1'b0, p_den};
    assign diff  = trial - {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= p_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k] && p_v) begin
        rem_r[k] <= ge ? diff[RW-1:0] : trial[RW-1:0];
        lo_r[k]  <= p_lo << 1;
        quo_r[k] <= {p_quo[S-2:0], ge};
        den_r[k] <= p_den;
        tag_r[k] <= p_tag;
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[S-1];
  assign out_quo   = quo_r[S-1];
  assign out_tag   = tag_r[S-1];

  // remainder of a finished division is below a non-zero divisor
  a_rem_lt_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[S-1] && den_r[S-1] != '0 |-> rem_r[S-1] < den_r[S-1])
    else $error("divider remainder not below divisor");

  // a held result keeps its quotient
  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[S-1] && !out_ready |=> v_r[S-1] && $stable(quo_r[S-1]))
    else $error("divider lost or changed a stalled result");

  // an accepted beat lands in the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("divider dropped an accepted beat");

endmodule

### rtl/ds_twr_tof_compute.sv
// Top level of the double-sided two-way-ranging time-of-flight block.
// Depends on dtwr_pkg, dtwr_in_if, dtwr_out_if and dtwr_div_pipe.
//
// Takes the six timestamps of one ranging exchange per beat and returns
// (Ra*Rb - Da*Db) / (Ra+Rb+Da+Db), truncated toward zero, as a signed 34-bit
// tick count; each interval is a difference that wraps at STAMP_BITS bits. An
// all-zero interval sum gives invalid = 1 and zero ticks. The block accepts a
// beat every cycle unless the result side stalls it. One stage forms the
// intervals and their sum, one the partial products, one the signed numerator,
// STAMP_BITS divider stages produce one quotient bit each, and an output
// register saturates to the 34-bit range. Every stage has its own valid bit
// and stalls only when full and blocked, so the pipeline keeps filling while a
// result waits.
module ds_twr_tof_compute import dtwr_pkg::*; #(
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  dtwr_in_if.sink  in_ch,
  dtwr_out_if.source out_ch
);

  localparam int unsigned S  = STAMP_BITS;
  localparam int unsigned DW = S + 2;           // interval sum
  localparam int unsigned NW = 2 * S;           // products and numerator
  localparam int unsigned LO = S / 2;           // multiplier split point
  localparam int unsigned HI = S - LO;
  localparam int unsigned EW = ((S > OUT_W) ? S : OUT_W) + 1;
  localparam logic [EW-1:0] POS_LIM = EW'(34'h1_FFFF_FFFF);
  localparam logic [EW-1:0] NEG_LIM = EW'(34'h2_0000_0000);

  // Stage 1: intervals and their sum
  logic          v1_r, rdy1;
  logic [S-1:0]  ra_r, rb_r, da_r, db_r;
  logic [DW-1:0] den1_r;

  // Stage 2: partial products, multiplier cut in two halves
  logic            v2_r, rdy2;
  logic [S+LO-1:0] p_lo_r, q_lo_r;
  logic [S+HI-1:0] p_hi_r, q_hi_r;
  logic [DW-1:0]   den2_r;

  // Stage 3: numerator magnitude and sign
  logic          v3_r, rdy3;
  logic [NW-1:0] num3_r;
  logic [DW-1:0] den3_r;
  dtwr_tag_t     tag3_r;

  // Divider handshake and results
  logic          div_rdy;
  logic          dv_valid, dv_ready;
  logic [S-1:0]  dv_quo;
  dtwr_tag_t     dv_tag;

  // Output register
  logic                    ov_r;
  logic signed [OUT_W-1:0] ft_r;
  logic                    inv_r;

  // Stage 3 advances only when it is empty or the divider's first stage takes the beat
  assign dv_ready    = !ov_r || out_ch.ready;
  assign rdy3        = !v3_r || div_rdy;
  assign rdy2        = !v2_r || rdy3;
  assign rdy1        = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  // Stage 1: wrap each difference to the stamp width
  logic [S-1:0]  ra_nxt, rb_nxt, da_nxt, db_nxt;
  always_comb begin
    ra_nxt = S'(in_ch.remote_resp_rx_time) - S'(in_ch.remote_poll_tx_time);
    rb_nxt = S'(in_ch.final_rx_time) - S'(in_ch.resp_tx_stamp);
    da_nxt = S'(in_ch.remote_final_tx_time) - S'(in_ch.remote_resp_rx_time);
    db_nxt = S'(in_ch.resp_tx_stamp) - S'(in_ch.poll_rx_time);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      ra_r   <= ra_nxt;
      rb_r   <= rb_nxt;
      da_r   <= da_nxt;
      db_r   <= db_nxt;
      den1_r <= DW'(ra_nxt) + DW'(rb_nxt) + DW'(da_nxt) + DW'(db_nxt);
    end
  end

  // Stage 2: four narrow products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      p_lo_r <= (S+LO)'(ra_r) * (S+LO)'(rb_r[LO-1:0]);
      p_hi_r <= (S+HI)'(ra_r) * (S+HI)'(rb_r[S-1:LO]);
      q_lo_r <= (S+LO)'(da_r) * (S+LO)'(db_r[LO-1:0]);
      q_hi_r <= (S+HI)'(da_r) * (S+HI)'(db_r[S-1:LO]);
      den2_r <= den1_r;
    end
  end

  // Stage 3: recombine, then take the magnitude of the difference
  logic [NW-1:0] prod_p, prod_q;
  logic          neg3_nxt;
  always_comb begin
    prod_p   = NW'(p_lo_r) + (NW'(p_hi_r) << LO);
    prod_q   = NW'(q_lo_r) + (NW'(q_hi_r) << LO);
    neg3_nxt = prod_p < prod_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      num3_r         <= neg3_nxt ? (prod_q - prod_p) : (prod_p - prod_q);
      den3_r         <= den2_r;
      tag3_r.neg     <= neg3_nxt;
      tag3_r.invalid <= den2_r == '0;
    end
  end

  dtwr_div_pipe #(
    .STAMP_BITS (STAMP_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (div_rdy),
    .in_num    (num3_r),
    .in_den    (den3_r),
    .in_tag    (tag3_r),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_quo   (dv_quo),
    .out_tag   (dv_tag)
  );

  // Output stage: saturate to the signed 34-bit range and apply the sign; an invalid beat gives zero
  logic [EW-1:0]           quo_x, mag;
  logic signed [OUT_W-1:0] ft_nxt;
  always_comb begin
    quo_x = EW'(dv_quo);
    if (dv_tag.neg) begin
      mag = (quo_x > NEG_LIM) ? NEG_LIM : quo_x;
    end else begin
      mag = (quo_x > POS_LIM) ? POS_LIM : quo_x;
    end
    if (dv_tag.invalid) begin
      ft_nxt = '0;
    end else if (dv_tag.neg) begin
      ft_nxt = -$signed(mag[OUT_W-1:0]);
    end else begin
      ft_nxt = $signed(mag[OUT_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (dv_ready) begin
      ov_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (dv_ready && dv_valid) begin
      ft_r  <= ft_nxt;
      inv_r <= dv_tag.invalid;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.flight_ticks = ft_r;
  assign out_ch.invalid      = inv_r;

  // an invalid beat always carries zero ticks
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.invalid |-> out_ch.flight_ticks == '0)
    else $error("invalid result with non-zero ticks");

  // an empty first stage never refuses a beat
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_ch.ready)
    else $error("input refused with empty first stage");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

endmodule

### verif/ds_twr_tof_check.sv
`timescale 1ns / 100ps
// Checker for the two-way-ranging time-of-flight block: watches both channels,
// predicts each flight result and compares it. Depends on dtwr_pkg and the channel interfaces.
module ds_twr_tof_check import dtwr_pkg::*; #(
  parameter int unsigned STAMP_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  dtwr_in_if.monitor  in_mon,
  dtwr_out_if.monitor out_mon,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    logic signed [OUT_W-1:0] ticks;
    logic                    invalid;
  } flight_t;

  flight_t flights_due[$];

  assign pending = flights_due.size();

  // Work out the flight result of one exchange, exactly in wide integers
  function automatic flight_t tof_of(input logic [IN_W-1:0] prx, rtx, frx,
                                     rptx, rrrx, rftx);
    flight_t                res;
    logic [63:0]            msk;
    logic [63:0]            ra, rb, da, db, den;
    logic signed [129:0]    num, quo;
    logic [129:0]           mag;
    msk = (64'd1 << STAMP_BITS) - 64'd1;
    ra = ({32'd0, rrrx} - {32'd0, rptx}) & msk;
    rb = ({32'd0, frx} - {32'd0, rtx}) & msk;
    da = ({32'd0, rftx} - {32'd0, rrrx}) & msk;
    db = ({32'd0, rtx} - {32'd0, prx}) & msk;
    den = ra + rb + da + db;
    res.invalid = 1'b0;
    res.ticks = '0;
    if (den == 64'd0) begin
      res.invalid = 1'b1;
    end else begin
      num = $signed({2'b00, 64'd0, ra} * {66'd0, rb}) - $signed({2'b00, 64'd0, da} * {66'd0, db});
      mag = (num < 0) ? 130'(-num) : 130'(num);
      mag = mag / {66'd0, den};
      // saturate to the signed 34-bit range
      if (num < 0) begin
        if (mag > 130'h200000000) mag = 130'h200000000;
        quo = -$signed(mag);
      end else begin
        if (mag > 130'h1FFFFFFFF) mag = 130'h1FFFFFFFF;
        quo = $signed(mag);
      end
      res.ticks = quo[OUT_W-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    flight_t want;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        flights_due.push_back(tof_of(in_mon.poll_rx_time, in_mon.resp_tx_stamp,
          in_mon.final_rx_time, in_mon.remote_poll_tx_time,
          in_mon.remote_resp_rx_time, in_mon.remote_final_tx_time));
      if (out_mon.valid && out_mon.ready) begin
        if (flights_due.size() == 0) begin
          report_mismatch("result beat with nothing due");
        end else begin
          want = flights_due.pop_front();
          if (out_mon.flight_ticks !== want.ticks)
            report_mismatch($sformatf("flight_ticks %0d, want %0d",
                            out_mon.flight_ticks, want.ticks));
          if (out_mon.invalid !== want.invalid)
            report_mismatch($sformatf("invalid %b, want %b",
                            out_mon.invalid, want.invalid));
        end
      end
    end
  end

endmodule

### verif/ds_twr_tof_compute_test.sv
`timescale 1ns / 100ps
// Testbench top for ds_twr_tof_compute: drives exchanges and result stalls,
// and gives the verdict. Depends on dtwr_pkg, the interfaces and ds_twr_tof_check.
module ds_twr_tof_compute_test;
  import dtwr_pkg::*;

  localparam int RANDOM_EXCHANGES = 900;
  localparam int STALL_LIMIT      = 2000;
  localparam int DRAIN_CYCLES     = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  bit   timed_out = 1'b0;

  dtwr_in_if  in_ch ();
  dtwr_out_if out_ch ();

  always #4 clk = ~clk;

  ds_twr_tof_compute uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  ds_twr_tof_check chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                        .fail_count(fail_count), .pending(pending));

  // Send one exchange: unless no_gap is set, idle a random number of cycles, then hold the beat until taken
  task automatic send_exchange(input logic [IN_W-1:0] prx, rtx, frx, rptx, rrrx, rftx,
                               input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid                <= 1'b1;
    in_ch.poll_rx_time         <= prx;
    in_ch.resp_tx_stamp        <= rtx;
    in_ch.final_rx_time        <= frx;
    in_ch.remote_poll_tx_time  <= rptx;
    in_ch.remote_resp_rx_time  <= rrrx;
    in_ch.remote_final_tx_time <= rftx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Build an exchange from a base and four intervals so that wrap-around is exercised
  task automatic send_intervals(input logic [31:0] lbase, rbase, ra, rb, da, db,
                                input bit no_gap);
    send_exchange(lbase, lbase + db, lbase + db + rb, rbase, rbase + ra,
                  rbase + ra + da, no_gap);
  endtask

  // Result side: stall for a random count before each beat, with quiet stretches
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Watchdog: count cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [31:0] s [6];
    bit burst;
    in_ch.valid                <= 1'b0;
    in_ch.poll_rx_time         <= '0;
    in_ch.resp_tx_stamp        <= '0;
    in_ch.final_rx_time        <= '0;
    in_ch.remote_poll_tx_time  <= '0;
    in_ch.remote_resp_rx_time  <= '0;
    in_ch.remote_final_tx_time <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero interval sum, extremes, wrap-around, both signs
    send_exchange('0, '0, '0, '0, '0, '0, 0);
    send_exchange('1, '1, '1, '1, '1, '1, 0);
    send_exchange(32'h1234_5678, 32'h1234_5678, 32'h1234_5678,
                  32'h9abc_def0, 32'h9abc_def0, 32'h9abc_def0, 0);
    send_exchange('1, '0, '1, '0, '1, '0, 0);
    send_exchange('0, '1, '0, '1, '0, '1, 1);
    send_intervals(32'hffff_ff00, 32'hffff_fff0, '1, '1, 0, 0, 1);
    send_intervals(32'h0, 32'h0, 0, 0, '1, '1, 1);
    send_intervals(32'h0, 32'h0, '1, 1, 1, '1, 0);
    send_intervals(32'h0, 32'h0, 1, 0, 0, 0, 0);
    send_intervals(32'h0, 32'h0, 0, 0, 0, 1, 0);
    send_intervals(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 0);
    send_intervals(32'hdead_beef, 32'h1357_9bdf, 3, 5, 2, 7, 0);
    send_intervals(32'h0, 32'h0, 1000, 1200, 800, 950, 0);
    send_intervals(32'h0, 32'h0, '1, '1, '1, '1, 1);
    send_intervals(32'h0, 32'h0, '1, '1, '1, 0, 1);

    // Random: half realistic ranging intervals, half full-range noise
    for (int n = 0; n < RANDOM_EXCHANGES; n++) begin
      burst = (n % 100) < 20;
      case ($urandom_range(0, 3))
        0: begin
          foreach (s[k]) s[k] = $urandom();
          send_exchange(s[0], s[1], s[2], s[3], s[4], s[5], burst);
        end
        1: begin
          send_intervals($urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), burst);
        end
        default: begin
          s[0] = $urandom_range(0, 1 << 20);
          s[1] = s[0] + $urandom_range(0, 1 << 12);
          send_intervals($urandom(), $urandom(), s[1], s[0] + $urandom_range(0, 255),
                         s[0], s[1] - $urandom_range(0, 255), burst);
        end
      endcase
    end
    in_ch.valid <= 1'b0;

    // Drain: wait for every result, then a little longer for strays
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
